/* sv/separable_box_blur_3x3_rgb_defines.svh */
// ----------------------------------------------------------------------------
// separable box blur assertion macros
// shared property shorthands for the blur modules
// ----------------------------------------------------------------------------
`ifndef SEPARABLE_BOX_BLUR_3X3_RGB_DEFINES_SVH
`define SEPARABLE_BOX_BLUR_3X3_RGB_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define SBB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbb assertion failed");

// next-cycle implication, disabled while reset is held
`define SBB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbb assertion failed");

`endif

/* sv/sbb_pkg.sv */
// ----------------------------------------------------------------------------
// sbb_pkg
// shared types, constants and the 3-tap mean for the box blur
// ----------------------------------------------------------------------------
package sbb_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 1024;
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;
    localparam int QUEUE_DEPTH  = 4;
    localparam int CFG_W        = 11;
    localparam int PIX_W        = 24;

    // register indexes of the configuration port
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // one vertical result pair and its position flags
    typedef struct packed {
        logic [PIX_W-1:0] v;        // vertical mean centred on the row above
        logic [PIX_W-1:0] vl;       // vertical mean of the mirrored bottom row
        logic             x_ge1;
        logic             x_is1;
        logic             x_last;
        logic             last_row;
    } t_entry;

    // floor(s/3) for s up to 765 by reciprocal multiply
    function automatic logic [7:0] div3(input logic [9:0] s);
        logic [20:0] p;
        p = 21'(s) * 21'd683;
        return p[18:11];
    endfunction

    // per-channel floor((a+b+c)/3), red in the low byte
    function automatic logic [PIX_W-1:0] mean3(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b,
                                                input logic [PIX_W-1:0] c);
        logic [PIX_W-1:0] res;
        logic [9:0]       s;
        res = '0;
        for (int ch = 0; ch < 3; ch++) begin
            s = 10'(a[ch*8 +: 8]) + 10'(b[ch*8 +: 8]) + 10'(c[ch*8 +: 8]);
            res[ch*8 +: 8] = div3(s);
        end
        return res;
    endfunction

endpackage

/* sv/sbb_front.sv */
// ----------------------------------------------------------------------------
// sbb_front
// raster counters, line memory and vertical 3-tap mean
// ----------------------------------------------------------------------------
module sbb_front #(
    parameter int MAX_WIDTH  = sbb_pkg::MAX_WIDTH,
    parameter int MAX_HEIGHT = sbb_pkg::MAX_HEIGHT,
    localparam int XW = $clog2(MAX_WIDTH),
    localparam int YW = $clog2(MAX_HEIGHT),
    localparam int CW = $clog2(sbb_pkg::QUEUE_DEPTH + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_restart,
    input  logic [XW-1:0]             i_w_last,
    input  logic [YW-1:0]             i_h_last,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [sbb_pkg::PIX_W-1:0] i_pixel,
    input  logic [CW-1:0]             i_queue_count,
    output logic                      o_push,
    output sbb_pkg::t_entry           o_entry
);

    logic [XW-1:0] r_col, n_col;
    logic [YW-1:0] r_row, n_row;
    logic          r_s1_v;
    logic          acc;

    // stage one payload
    logic [sbb_pkg::PIX_W-1:0]   r_cur;
    logic [2*sbb_pkg::PIX_W-1:0] r_rd;
    logic [XW-1:0]               r_xa;
    logic r_x_ge1, r_x_is1, r_x_last, r_y_ge1, r_y_is1, r_y_last;

    // line memory: low half the row above, high half two rows above
    logic [2*sbb_pkg::PIX_W-1:0] r_mem [MAX_WIDTH];

    logic [sbb_pkg::PIX_W-1:0] one, two;

    // room for this item and the one in flight
    assign o_ready = (i_queue_count < CW'(sbb_pkg::QUEUE_DEPTH - 1))
                     || ((i_queue_count == CW'(sbb_pkg::QUEUE_DEPTH - 1)) && !r_s1_v);
    assign acc = i_valid && o_ready;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (acc) begin
            if (r_col == i_w_last) begin
                n_col = '0;
                n_row = (r_row == i_h_last) ? '0 : r_row + YW'(1);
            end else begin
                n_col = r_col + XW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_s1_v <= 1'b0;
        end else if (i_restart) begin
            r_col  <= '0;
            r_row  <= '0;
            r_s1_v <= 1'b0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_s1_v <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_cur    <= i_pixel;
            r_xa     <= r_col;
            r_x_ge1  <= (r_col != '0);
            r_x_is1  <= (r_col == XW'(1));
            r_x_last <= (r_col == i_w_last);
            r_y_ge1  <= (r_row != '0);
            r_y_is1  <= (r_row == YW'(1));
            r_y_last <= (r_row == i_h_last);
        end
    end

    // registered read at the incoming column, written back in the following cycle
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_col];
        if (r_s1_v) begin
            r_mem[r_xa] <= {r_rd[sbb_pkg::PIX_W-1:0], r_cur};
        end
    end

    assign one = r_rd[sbb_pkg::PIX_W-1:0];
    assign two = r_rd[2*sbb_pkg::PIX_W-1:sbb_pkg::PIX_W];

    always_comb begin
        o_entry.v        = r_y_is1 ? sbb_pkg::mean3(r_cur, one, r_cur)
                                   : sbb_pkg::mean3(two, one, r_cur);
        o_entry.vl       = sbb_pkg::mean3(one, r_cur, one);
        o_entry.x_ge1    = r_x_ge1;
        o_entry.x_is1    = r_x_is1;
        o_entry.x_last   = r_x_last;
        o_entry.last_row = r_y_last;
    end

    // row zero only fills the line memory
    assign o_push = r_s1_v && r_y_ge1;

endmodule

/* sv/sbb_queue.sv */
// ----------------------------------------------------------------------------
// sbb_queue
// short queue of vertical results between front and back
// ----------------------------------------------------------------------------
`include "separable_box_blur_3x3_rgb_defines.svh"

module sbb_queue #(
    localparam int DEPTH = sbb_pkg::QUEUE_DEPTH,
    localparam int PW    = $clog2(DEPTH),
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sbb_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_valid,
    output sbb_pkg::t_entry o_head,
    output logic [CW-1:0]   o_count
);

    sbb_pkg::t_entry r_slot [DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_head  = r_slot[r_rd_ptr];
    assign o_count = r_count;

    `SBB_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, r_count < CW'(DEPTH))
    `SBB_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_pop, r_count != '0)
    `SBB_ASSERT_NXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + CW'(1))

endmodule

/* sv/sbb_back.sv */
// ----------------------------------------------------------------------------
// sbb_back
// horizontal 3-tap mean, result sequencing and output register
// ----------------------------------------------------------------------------
`include "separable_box_blur_3x3_rgb_defines.svh"

module sbb_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  sbb_pkg::t_entry           i_head,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [sbb_pkg::PIX_W-1:0] o_data,
    output logic                      o_last,
    output logic                      o_frame_last
);

    typedef enum logic [1:0] {
        K_MAIN, K_MAIN_EDGE, K_BOTTOM, K_BOTTOM_EDGE
    } t_kind;

    logic [sbb_pkg::PIX_W-1:0] r_w0, r_w1, r_l0, r_l1;
    logic [3:0]                r_done;
    logic                      r_o_valid, r_o_last, r_o_frame_last;
    logic [sbb_pkg::PIX_W-1:0] r_o_data;

    logic [3:0]                mask, rem, bit_sel, rest;
    t_kind                     kind;
    logic                      out_free, emit;
    logic [sbb_pkg::PIX_W-1:0] a, b, c;

    assign mask = {i_head.last_row & i_head.x_last, i_head.last_row & i_head.x_ge1,
                   i_head.x_last, i_head.x_ge1};
    assign rem  = mask & ~r_done;

    always_comb begin
        priority if (rem[0]) begin
            kind = K_MAIN;        bit_sel = 4'b0001;
        end else if (rem[1]) begin
            kind = K_MAIN_EDGE;   bit_sel = 4'b0010;
        end else if (rem[2]) begin
            kind = K_BOTTOM;      bit_sel = 4'b0100;
        end else begin
            kind = K_BOTTOM_EDGE; bit_sel = 4'b1000;
        end
    end

    // mirrored left edge at column one, mirrored right edge at the last column
    always_comb begin
        unique case (kind)
            K_MAIN: begin
                a = i_head.x_is1 ? i_head.v : r_w0; b = r_w1; c = i_head.v;
            end
            K_MAIN_EDGE: begin
                a = r_w1; b = i_head.v; c = r_w1;
            end
            K_BOTTOM: begin
                a = i_head.x_is1 ? i_head.vl : r_l0; b = r_l1; c = i_head.vl;
            end
            default: begin
                a = r_l1; b = i_head.vl; c = r_l1;
            end
        endcase
    end

    assign rest     = rem & ~bit_sel;
    assign out_free = !r_o_valid || i_ready;
    assign emit     = i_valid && (rem != '0) && out_free;
    assign o_pop    = i_valid && ((rem == '0) || (emit && (rest == '0)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_done    <= '0;
            r_w0      <= '0;
            r_w1      <= '0;
            r_l0      <= '0;
            r_l1      <= '0;
        end else begin
            if (out_free) begin
                r_o_valid <= emit;
            end
            if (o_pop) begin
                r_done <= '0;
                r_w0   <= r_w1;
                r_w1   <= i_head.v;
                if (i_head.last_row) begin
                    r_l0 <= r_l1;
                    r_l1 <= i_head.vl;
                end
            end else if (emit) begin
                r_done <= r_done | bit_sel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_data       <= sbb_pkg::mean3(a, b, c);
            r_o_last       <= (rest == '0);
            r_o_frame_last <= (kind == K_BOTTOM_EDGE);
        end
    end

    assign o_valid      = r_o_valid;
    assign o_data       = r_o_data;
    assign o_last       = r_o_last;
    assign o_frame_last = r_o_frame_last;

    `SBB_ASSERT_IMP(a_frame_end_is_last, i_clk, i_rst_n, r_o_valid && r_o_frame_last, r_o_last)
    `SBB_ASSERT_IMP(a_pop_needs_head, i_clk, i_rst_n, o_pop, i_valid)

endmodule

/* sv/separable_box_blur_3x3_rgb.sv */
// path: input register with the line-memory read, then the queue, then the output register
// throughput: one pixel per cycle while the queue has room; a last-column input yields 2
// results, 4 on the last row, and every other last-row pixel past column zero yields 2; the
// 4-entry queue between passes absorbs them, and with the output ready sends one per cycle
// reset: synchronous, active low; clears counters, queue, windows and output valid
// line memory is not cleared: every entry is written in a frame before it is read
// ----------------------------------------------------------------------------
// separable_box_blur_3x3_rgb
// streaming 3x3 box blur, vertical then horizontal floor mean, mirrored borders
// ----------------------------------------------------------------------------
module separable_box_blur_3x3_rgb #(
    parameter int MAX_WIDTH  = sbb_pkg::MAX_WIDTH,
    parameter int MAX_HEIGHT = sbb_pkg::MAX_HEIGHT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // pixel input stream
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [23:0]                s_axis_tdata,   // pixel_red, pixel_green, pixel_blue
    // filtered output stream
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [23:0]                m_axis_tdata,   // out_red, out_green, out_blue
    output logic                       m_axis_tlast,   // run_last
    output logic                       m_axis_tuser,   // frame_last
    // configuration write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic                       i_cfg_index,
    input  logic [sbb_pkg::CFG_W-1:0]  i_cfg_data
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int CW = $clog2(sbb_pkg::QUEUE_DEPTH + 1);

    // reset sizes, clamped to the maxima, stored as last index
    localparam logic [XW-1:0] WLastReset = XW'(((sbb_pkg::RESET_WIDTH > MAX_WIDTH)
                                                ? MAX_WIDTH : sbb_pkg::RESET_WIDTH) - 1);
    localparam logic [YW-1:0] HLastReset = YW'(((sbb_pkg::RESET_HEIGHT > MAX_HEIGHT)
                                                ? MAX_HEIGHT : sbb_pkg::RESET_HEIGHT) - 1);

    logic [XW-1:0] r_w_last, w_last_in;
    logic [YW-1:0] r_h_last, h_last_in;
    logic          cfg_xfer;

    logic            push, pop, head_valid;
    sbb_pkg::t_entry entry, head;
    logic [CW-1:0]   queue_count;

    // configuration: always ready, a transfer restarts the frame
    assign o_cfg_ready = 1'b1;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;

    // sizes below 2 count as 2, above the maximum as the maximum
    always_comb begin
        if (i_cfg_data < sbb_pkg::CFG_W'(2)) begin
            w_last_in = XW'(1);
            h_last_in = YW'(1);
        end else begin
            w_last_in = (32'(i_cfg_data) > 32'(MAX_WIDTH)) ? XW'(MAX_WIDTH - 1)
                                                           : XW'(i_cfg_data - 1'b1);
            h_last_in = (32'(i_cfg_data) > 32'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT - 1)
                                                            : YW'(i_cfg_data - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last <= WLastReset;
            r_h_last <= HLastReset;
        end else if (cfg_xfer) begin
            unique case (i_cfg_index)
                sbb_pkg::REG_IMAGE_WIDTH:  r_w_last <= w_last_in;
                sbb_pkg::REG_IMAGE_HEIGHT: r_h_last <= h_last_in;
                default:                   r_w_last <= r_w_last;
            endcase
        end
    end

    // front: raster position, line memory, vertical mean
    sbb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_restart     (cfg_xfer),
        .i_w_last      (r_w_last),
        .i_h_last      (r_h_last),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_pixel       (s_axis_tdata),
        .i_queue_count (queue_count),
        .o_push        (push),
        .o_entry       (entry)
    );

    // queue decouples one pixel per cycle in from bursts of results out
    sbb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_head  (head),
        .o_count (queue_count)
    );

    // back: horizontal mean, up to four results per entry, output register
    sbb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_data       (m_axis_tdata),
        .o_last       (m_axis_tlast),
        .o_frame_last (m_axis_tuser)
    );

endmodule

/* bench/separable_box_blur_3x3_rgb_test.sv */
// ----------------------------------------------------------------------------
// separable_box_blur_3x3_rgb_test
// drives pixel frames of many sizes through the blur and checks every
// filtered pixel, its run flag and its frame flag against an in-bench model
// ----------------------------------------------------------------------------
module separable_box_blur_3x3_rgb_test;

    // one filtered pixel as it should leave the block
    typedef struct packed {
        logic [23:0] rgb;
        logic        run_last;
        logic        frame_last;
    } t_blurred_px;

    // bench model of the blur plus the queue of filtered pixels still owed
    class blur_scoreboard;
        logic [23:0]               row_above [sbb_pkg::MAX_WIDTH];
        logic [23:0]               row_two_above [sbb_pkg::MAX_WIDTH];
        logic [23:0]               win [2][2];      // [0] vertical results, [1] mirrored bottom row
        int unsigned               col;
        int unsigned               row;
        logic [sbb_pkg::CFG_W-1:0] width_reg;
        logic [sbb_pkg::CFG_W-1:0] height_reg;
        t_blurred_px               blurred_q [$];
        t_blurred_px               batch [$];
        int                        fails;

        function new();
            foreach (row_above[i]) begin
                row_above[i]     = '0;
                row_two_above[i] = '0;
            end
            foreach (win[k, j]) win[k][j] = '0;
            col        = 0;
            row        = 0;
            width_reg  = sbb_pkg::CFG_W'(sbb_pkg::RESET_WIDTH);
            height_reg = sbb_pkg::CFG_W'(sbb_pkg::RESET_HEIGHT);
            fails      = 0;
        endfunction

        function int unsigned clamp_size(int unsigned v, int unsigned hi);
            if (v < 2) return 2;
            if (v > hi) return hi;
            return v;
        endfunction

        // floor of the three-sample mean, each colour on its own
        function logic [23:0] avg3(logic [23:0] a, logic [23:0] b, logic [23:0] c);
            logic [23:0] res;
            int unsigned s;
            for (int ch = 0; ch < 3; ch++) begin
                s = a[ch*8 +: 8] + b[ch*8 +: 8] + c[ch*8 +: 8];
                res[ch*8 +: 8] = 8'(s / 3);
            end
            return res;
        endfunction

        function void add_result(logic [23:0] rgb, logic frame_end);
            t_blurred_px px;
            px.rgb        = rgb;
            px.run_last   = 1'b0;
            px.frame_last = frame_end;
            batch.push_back(px);
        endfunction

        // horizontal pass over one vertical result, left and right borders mirrored
        function void slide(int k, logic [23:0] v, int unsigned x, int unsigned w,
                            logic frame_end);
            if (x == 1)
                add_result(avg3(v, win[k][1], v), 1'b0);
            else if (x >= 2)
                add_result(avg3(win[k][0], win[k][1], v), 1'b0);
            if (x == w - 1)
                add_result(avg3(win[k][1], v, win[k][1]), frame_end);
            win[k][0] = win[k][1];
            win[k][1] = v;
        endfunction

        function void write_reg(logic idx, logic [sbb_pkg::CFG_W-1:0] val);
            if (idx == sbb_pkg::REG_IMAGE_WIDTH)
                width_reg = val;
            else
                height_reg = val;
            // any write starts a fresh frame
            col = 0;
            row = 0;
        endfunction

        function void note_pixel(logic [23:0] cur);
            int unsigned w;
            int unsigned h;
            int unsigned x;
            int unsigned y;
            logic [23:0] one;
            logic [23:0] two;
            w = clamp_size(width_reg, sbb_pkg::MAX_WIDTH);
            h = clamp_size(height_reg, sbb_pkg::MAX_HEIGHT);
            x = (col >= w) ? 0 : col;
            y = (row >= h) ? 0 : row;
            one = row_above[x];
            two = row_two_above[x];
            batch.delete();
            if (y >= 1) begin
                // top border mirrors the row below
                slide(0, (y == 1) ? avg3(cur, one, cur) : avg3(two, one, cur), x, w, 1'b0);
                if (y == h - 1)
                    slide(1, avg3(one, cur, one), x, w, 1'b1);
            end
            row_two_above[x] = one;
            row_above[x]     = cur;
            x++;
            if (x >= w) begin
                x = 0;
                y++;
                if (y >= h) y = 0;
            end
            col = x;
            row = y;
            if (batch.size() > 0) batch[batch.size()-1].run_last = 1'b1;
            foreach (batch[i]) blurred_q.push_back(batch[i]);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                fails++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
            end
        endfunction

        function void check_pixel(logic [23:0] rgb, logic tlast, logic tuser);
            t_blurred_px want;
            if (blurred_q.size() == 0) begin
                fails++;
                $display("%0t: unexpected result, expected none, actual %0h last %0b user %0b",
                         $time, rgb, tlast, tuser);
                return;
            end
            want = blurred_q.pop_front();
            compare_field("red",        want.rgb[7:0],   rgb[7:0]);
            compare_field("green",      want.rgb[15:8],  rgb[15:8]);
            compare_field("blue",       want.rgb[23:16], rgb[23:16]);
            compare_field("run_last",   8'(want.run_last),   8'(tlast));
            compare_field("frame_last", 8'(want.frame_last), 8'(tuser));
        endfunction

        function int pending();
            return blurred_q.size();
        endfunction
    endclass

    localparam int IDLE_LIMIT   = 3000;
    localparam int RANDOM_ITEMS = 250;

    // directed 3x3 frame: extremes of every channel in every position
    localparam logic [23:0] CORNER_FRAME [9] = '{
        24'h000000, 24'hFFFFFF, 24'h000000,
        24'hFF00FF, 24'hFFFFFF, 24'h00FF00,
        24'hFFFFFF, 24'h000000, 24'hFFFFFF
    };

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [23:0]               s_axis_tdata  = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [23:0]               m_axis_tdata;
    logic                      m_axis_tlast;
    logic                      m_axis_tuser;
    logic                      i_cfg_valid   = 1'b0;
    logic                      o_cfg_ready;
    logic                      i_cfg_index   = sbb_pkg::REG_IMAGE_WIDTH;
    logic [sbb_pkg::CFG_W-1:0] i_cfg_data    = '0;

    blur_scoreboard board = new();
    bit             steady = 1'b0;    // phase with no idling on either side
    int             ready_hold = 0;
    int             idle_cycles = 0;

    separable_box_blur_3x3_rgb DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // pixel_red, pixel_green, pixel_blue
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // out_red, out_green, out_blue
        .m_axis_tlast  (m_axis_tlast),    // run_last
        .m_axis_tuser  (m_axis_tuser),    // frame_last
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // output back-pressure, held for random stretches
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
        end else if (steady || $urandom_range(0, 3) != 0) begin
            m_axis_tready <= 1'b1;
            ready_hold = $urandom_range(0, 12);
        end else begin
            m_axis_tready <= 1'b0;
            ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                     : $urandom_range(0, 3);
        end
    end

    // monitor: every transfer is seen here, results checked before the new pixel
    // is noted; the watchdog counts cycles with no transfer at all
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_pixel(m_axis_tdata, m_axis_tlast, m_axis_tuser);
            if (s_axis_tvalid && s_axis_tready)
                board.note_pixel(s_axis_tdata);
            if (i_cfg_valid && o_cfg_ready)
                board.write_reg(i_cfg_index, i_cfg_data);
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // one pixel transfer; valid stays high into the next pixel unless a gap is taken
    task automatic push_pixel(input logic [23:0] pix);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic feed_random(input int n);
        for (int i = 0; i < n; i++) push_pixel(24'($urandom()));
    endtask

    // drain: wait until the last transfer is noted and all owed results are back,
    // then let pixels with no result clear the pipe
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic configure(input bit do_w, input int w, input bit do_h, input int h);
        if (do_w) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= sbb_pkg::REG_IMAGE_WIDTH;
            i_cfg_data  <= sbb_pkg::CFG_W'(w);
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        if (do_h) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= sbb_pkg::REG_IMAGE_HEIGHT;
            i_cfg_data  <= sbb_pkg::CFG_W'(h);
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int frame_dim(input int v, input int hi);
        if (v < 2) return 2;
        if (v > hi) return hi;
        return v;
    endfunction

    initial begin
        int w;
        int h;
        int fw;
        int fh;
        int n;
        int pick;
        int random_items;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sizes straight out of reset: part of the first 640 wide row, nothing owed yet
        feed_random(16);
        settle();

        // directed: one full 3x3 frame of extreme samples
        configure(1'b1, 3, 1'b1, 3);
        foreach (CORNER_FRAME[i]) push_pixel(CORNER_FRAME[i]);
        settle();

        // sizes below the floor count as 2x2
        configure(1'b1, 1, 1'b1, 0);
        push_pixel(24'hFFFFFF);
        push_pixel(24'h000000);
        push_pixel(24'h000000);
        push_pixel(24'hFFFFFF);
        settle();

        // random small frames, often cut short by the next write
        w = 2;
        h = 2;
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 3);
            if (pick != 1)
                w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 9);
            if (pick != 0) begin
                case ($urandom_range(0, 9))
                    0: h = $urandom_range(0, 1);
                    1: h = $urandom_range(sbb_pkg::MAX_HEIGHT + 1, 2047);
                    default: h = $urandom_range(2, 7);
                endcase
            end
            fw = frame_dim(w, sbb_pkg::MAX_WIDTH);
            fh = frame_dim(h, sbb_pkg::MAX_HEIGHT);
            if (fh > 8)
                n = fw * $urandom_range(3, 8);
            else
                n = fw * fh * $urandom_range(1, 2) +
                    (($urandom_range(0, 1) == 1) ? $urandom_range(0, fw * fh - 1) : 0);
            if (n > RANDOM_ITEMS - random_items)
                n = RANDOM_ITEMS - random_items;
            steady = ($urandom_range(0, 3) == 0);
            configure(pick != 1, w, pick != 0, h);
            feed_random(n);
            settle();
            random_items += n;
        end

        repeat (10) @(posedge i_clk);
        if (board.fails == 0 && board.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/sbb_pkg.sv
sv/sbb_front.sv
sv/sbb_queue.sv
sv/sbb_back.sv
sv/separable_box_blur_3x3_rgb.sv
bench/separable_box_blur_3x3_rgb_test.sv
